// ===== src/nsim_pkg.sv =====
// Package for the nearest storm id match block.
// Holds the sequencer state type and the fixed field widths, codes and character constants.
// No dependencies.
package nsim_pkg;

    // Fixed field widths
    localparam int ID_BITS    = 9;
    localparam int COUNT_BITS = 8;
    localparam int GATE_BITS  = 12;
    localparam int IDX_BITS   = 7;
    localparam int CHAR_BITS  = 8;
    localparam int APB_DATA   = 32;
    localparam int APB_ADDR   = 3;

    // Operation codes of an input item
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_STORM_COUNT    = 1'b0;
    localparam logic REG_MAX_ASSOC_DIST = 1'b1;

    // Register reset values
    localparam logic [COUNT_BITS-1:0] STORM_COUNT_RST = 8'd0;
    localparam logic [GATE_BITS-1:0]  GATE_RST        = 12'd320;

    // Id conversion: m / 26 by reciprocal 315 / 2^13, one correction step
    localparam logic [4:0]  NUM_LETTERS = 5'd26;
    localparam logic [8:0]  RECIP_26    = 9'd315;
    localparam int          RECIP_SHIFT = 13;

    // ASCII characters
    localparam logic [CHAR_BITS-1:0] ASCII_A        = 8'h41;
    localparam logic [CHAR_BITS-1:0] ASCII_0        = 8'h30;
    localparam logic [CHAR_BITS-1:0] UNMATCHED_CHAR = 8'h3F;

    // Query sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CONV,
        ST_OUT
    } t_state;

endpackage

// ===== src/nsim_if.sv =====
// Handshake channels of the nearest storm id match block: input items and result items.
// Valid/ready handshake; an item moves when both are high at a rising edge.
// Depends on nsim_pkg for the fixed field widths.
interface nsim_in_if #(
    parameter int COORD_BITS = 14
);
    import nsim_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [IDX_BITS-1:0]          entry_index;
    logic signed [COORD_BITS-1:0] x_pos;
    logic signed [COORD_BITS-1:0] y_pos;
    logic [ID_BITS-1:0]           load_number;

    modport source (
        output valid, operation, entry_index, x_pos, y_pos, load_number,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, x_pos, y_pos, load_number,
        output ready
    );
endinterface

interface nsim_out_if;
    import nsim_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 matched;
    logic [CHAR_BITS-1:0] id_letter;
    logic [CHAR_BITS-1:0] id_digit;
    logic [ID_BITS-1:0]   matched_number;

    modport source (
        output valid, matched, id_letter, id_digit, matched_number,
        input  ready
    );
    modport sink (
        input  valid, matched, id_letter, id_digit, matched_number,
        output ready
    );
endinterface

// ===== src/nearest_storm_id_match_core.sv =====
// Nearest storm id match: a query walks N stored storms, N = storm_count capped at MAX_STORMS;
// the walk feeds one stored storm per cycle from the table RAM through one pipelined
// distance/compare unit, then the ST_CONV and ST_OUT states convert the id. The block takes
// no new item while a query is in progress, and a result that still waits in the output
// register holds the block in ST_OUT. Synchronous active-low reset clears
// the sequencer, registers (storm_count 0, gate 320) and valids; the storm table is not cleared.
module nearest_storm_id_match_core #(
    parameter int MAX_STORMS = 128,
    parameter int COORD_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nsim_in_if.sink                        i_query,
    nsim_out_if.source                     o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nsim_pkg::APB_ADDR-1:0]  paddr,
    input  logic [nsim_pkg::APB_DATA-1:0]  pwdata,
    output logic [nsim_pkg::APB_DATA-1:0]  prdata,
    output logic                           pready
);
    import nsim_pkg::*;

    // Derived widths
    localparam int AW    = (MAX_STORMS > 1) ? $clog2(MAX_STORMS) : 1;
    localparam int LW    = $clog2(MAX_STORMS + 1);
    localparam int CMPW  = (LW > COUNT_BITS) ? LW : COUNT_BITS;
    localparam int IW    = (AW > IDX_BITS) ? AW : IDX_BITS;
    localparam int SQW   = 2 * COORD_BITS;
    localparam int DW0   = SQW + 1;
    localparam int DW    = (DW0 > 2 * GATE_BITS) ? DW0 : 2 * GATE_BITS;
    localparam int WORDW = 2 * COORD_BITS + ID_BITS;

    // Configuration registers
    logic [COUNT_BITS-1:0] r_storm_count;
    logic [GATE_BITS-1:0]  r_max_dist;
    logic                  cfg_we;

    // Sequencer
    t_state r_state, n_state;
    logic   query_ready, issue_en, pipe_empty, out_load, walk_done;

    // Query context
    logic signed [COORD_BITS-1:0] r_fx, r_fy;
    logic [2*GATE_BITS-1:0]       r_gate2;
    logic [LW-1:0]                r_limit, r_issue;

    // Distance pipeline
    logic                         r_v1, r_v2, r_v3;
    logic [WORDW-1:0]             rd_word;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [ID_BITS-1:0]           rd_num;
    logic signed [COORD_BITS:0]   dx_s, dy_s;
    logic [COORD_BITS-1:0]        r_dx, r_dy;
    logic [ID_BITS-1:0]           r_num2, r_num3;
    logic [SQW-1:0]               r_sqx, r_sqy;
    logic [DW-1:0]                d2;
    logic                         take;

    // Best candidate
    logic                 r_found;
    logic [DW-1:0]        r_best;
    logic [ID_BITS-1:0]   r_best_num;

    // Id conversion
    logic [ID_BITS-1:0]   r_m;
    logic [4:0]           r_q0;
    logic [2*ID_BITS-1:0] q_prod;
    logic [ID_BITS:0]     rem0;
    logic [4:0]           q_fix;
    logic [4:0]           rem_fix;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_matched;
    logic [CHAR_BITS-1:0] r_out_letter, r_out_digit;
    logic [ID_BITS-1:0]   r_out_number;

    // Load path
    logic [IW-1:0] load_idx;
    logic          load_we;
    logic          in_acc;
    logic [CMPW-1:0] cnt_ext;

    // APB side
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_STORM_COUNT:    prdata = APB_DATA'(r_storm_count);
            REG_MAX_ASSOC_DIST: prdata = APB_DATA'(r_max_dist);
            default:            prdata = '0;
        endcase
    end

    // Input handshake and table writes
    assign in_acc   = i_query.valid && query_ready;
    assign load_idx = IW'(i_query.entry_index);
    assign load_we  = in_acc && (i_query.operation == OP_LOAD)
                      && ({1'b0, load_idx} < (IW + 1)'(MAX_STORMS));
    assign cnt_ext  = CMPW'(r_storm_count);

    nsim_ram #(
        .WIDTH (WORDW),
        .DEPTH (MAX_STORMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_idx[AW-1:0]),
        .i_wdata ({i_query.load_number, i_query.y_pos, i_query.x_pos}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rd_word)
    );

    // Unpack table word, abs differences
    assign rd_x   = rd_word[COORD_BITS-1:0];
    assign rd_y   = rd_word[2*COORD_BITS-1:COORD_BITS];
    assign rd_num = rd_word[WORDW-1:2*COORD_BITS];
    assign dx_s   = {rd_x[COORD_BITS-1], rd_x} - {r_fx[COORD_BITS-1], r_fx};
    assign dy_s   = {rd_y[COORD_BITS-1], rd_y} - {r_fy[COORD_BITS-1], r_fy};

    // Sum and gate compare; strict < keeps the earlier slot on a tie
    assign d2   = DW'(r_sqx) + DW'(r_sqy);
    assign take = r_v3 && (d2 < DW'(r_gate2)) && (!r_found || (d2 < r_best));

    // Id conversion arithmetic
    assign q_prod  = (2 * ID_BITS)'(r_m) * (2 * ID_BITS)'(RECIP_26);
    assign rem0    = {1'b0, r_m} - ((ID_BITS + 1)'(r_q0) * (ID_BITS + 1)'(NUM_LETTERS));
    assign q_fix   = (rem0 >= (ID_BITS + 1)'(NUM_LETTERS)) ? r_q0 + 5'd1 : r_q0;
    assign rem_fix = (rem0 >= (ID_BITS + 1)'(NUM_LETTERS))
                     ? 5'(rem0 - (ID_BITS + 1)'(NUM_LETTERS)) : 5'(rem0);

    // Sequencer control outputs
    always_comb begin
        pipe_empty  = !r_v1 && !r_v2 && !r_v3;
        walk_done   = (r_issue == r_limit);
        query_ready = (r_state == ST_IDLE);
        issue_en    = (r_state == ST_WALK) && !walk_done;
        out_load    = (r_state == ST_OUT) && (!r_out_valid || o_result.ready);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_query.operation == OP_QUERY)) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_done && pipe_empty) n_state = ST_CONV;
            end
            ST_CONV: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_query.ready = query_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_storm_count <= STORM_COUNT_RST;
            r_max_dist    <= GATE_RST;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                case (paddr[2])
                    REG_STORM_COUNT:    r_storm_count <= pwdata[COUNT_BITS-1:0];
                    REG_MAX_ASSOC_DIST: r_max_dist    <= pwdata[GATE_BITS-1:0];
                    default: ;
                endcase
            end
            r_v1 <= issue_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (in_acc && (i_query.operation == OP_QUERY)) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Query start: latch position, gate squared and walk length
        if (in_acc && (i_query.operation == OP_QUERY)) begin
            r_fx    <= i_query.x_pos;
            r_fy    <= i_query.y_pos;
            r_gate2 <= (2 * GATE_BITS)'(r_max_dist) * (2 * GATE_BITS)'(r_max_dist);
            r_limit <= (cnt_ext > CMPW'(MAX_STORMS)) ? LW'(MAX_STORMS) : LW'(r_storm_count);
            r_issue <= '0;
        end else if (issue_en) begin
            r_issue <= r_issue + LW'(1);
        end
        // Abs difference stage
        r_dx   <= dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
        r_dy   <= dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
        r_num2 <= rd_num;
        // Square stage
        r_sqx  <= SQW'(r_dx) * SQW'(r_dx);
        r_sqy  <= SQW'(r_dy) * SQW'(r_dy);
        r_num3 <= r_num2;
        // Best candidate update
        if (take) begin
            r_best     <= d2;
            r_best_num <= r_num3;
        end
        // Id conversion: first quotient estimate
        if (r_state == ST_CONV) begin
            r_q0 <= q_prod[RECIP_SHIFT+4:RECIP_SHIFT];
        end
        if (r_state == ST_WALK) begin
            r_m <= r_best_num - ID_BITS'(1);
        end
        // Result register
        if (out_load) begin
            r_out_matched <= r_found;
            if (r_found) begin
                r_out_letter <= ASCII_A + CHAR_BITS'(rem_fix);
                r_out_digit  <= ASCII_0 + CHAR_BITS'(q_fix);
                r_out_number <= r_best_num;
            end else begin
                r_out_letter <= UNMATCHED_CHAR;
                r_out_digit  <= UNMATCHED_CHAR;
                r_out_number <= '0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.matched        = r_out_matched;
    assign o_result.id_letter      = r_out_letter;
    assign o_result.id_digit       = r_out_digit;
    assign o_result.matched_number = r_out_number;

    // Distance pipeline is only busy during the walk
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_WALK) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("distance pipeline active outside walk");

    // Walk never reads past its limit
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_issue <= r_limit))
        else $error("walk address past limit");

    // A recorded best always lies strictly inside the gate
    a_best_in_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best < DW'(r_gate2)))
        else $error("best candidate outside gate");

    // Leaving the result state always leaves a valid result behind
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && n_state == ST_IDLE) |=> r_out_valid)
        else $error("result state left without a loaded result");
endmodule

// ===== src/nsim_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module nsim_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== bench/testbench.sv =====
// Testbench for nearest_storm_id_match_core: loads storm tables, runs queries, checks the ids.
// A scoreboard class predicts each query result; bursty item traffic, result stalls and APB writes.
// Depends on nsim_pkg, the nsim_in_if / nsim_out_if interfaces and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import nsim_pkg::*;

    localparam int MAX_STORMS    = 128;
    localparam int COORD_BITS    = 14;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 150;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 45;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic                         op;
        logic [IDX_BITS-1:0]          idx;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ID_BITS-1:0]           num;
    } t_storm_item;

    typedef struct packed {
        logic                 matched;
        logic [CHAR_BITS-1:0] letter;
        logic [CHAR_BITS-1:0] digit;
        logic [ID_BITS-1:0]   number;
    } t_storm_id;

    // Shadow of the storm table and registers; queues the id each query should produce
    class storm_assoc_board;
        logic signed [COORD_BITS-1:0] x_tab[MAX_STORMS];
        logic signed [COORD_BITS-1:0] y_tab[MAX_STORMS];
        logic [ID_BITS-1:0]           id_tab[MAX_STORMS];
        logic [COUNT_BITS-1:0]        storm_count;
        logic [GATE_BITS-1:0]         gate;
        t_storm_id                    due_ids[$];
        int                           mismatches;

        function new();
            int i;
            for (i = 0; i < MAX_STORMS; i++) begin
                x_tab[i]  = '0;
                y_tab[i]  = '0;
                id_tab[i] = '0;
            end
            storm_count = STORM_COUNT_RST;
            gate        = GATE_RST;
            mismatches  = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void set_register(logic idx, logic [APB_DATA-1:0] value);
            if (idx == REG_STORM_COUNT)
                storm_count = value[COUNT_BITS-1:0];
            else
                gate = value[GATE_BITS-1:0];
        endfunction

        // Nearest stored storm strictly inside the gate; lower slot wins a tie
        function t_storm_id nearest_id(logic signed [COORD_BITS-1:0] fx,
                                       logic signed [COORD_BITS-1:0] fy);
            t_storm_id          r;
            int                 lim;
            int                 i;
            longint             gate2;
            longint             best;
            longint             dx;
            longint             dy;
            longint             d2;
            bit                 found;
            logic [ID_BITS-1:0] best_num;
            logic [ID_BITS-1:0] m;
            lim      = (storm_count > MAX_STORMS) ? MAX_STORMS : int'(storm_count);
            gate2    = longint'(gate) * longint'(gate);
            found    = 1'b0;
            best     = 0;
            best_num = '0;
            for (i = 0; i < lim; i++) begin
                dx = longint'(x_tab[i]) - longint'(fx);
                dy = longint'(y_tab[i]) - longint'(fy);
                d2 = dx * dx + dy * dy;
                if (d2 < gate2 && (!found || d2 < best)) begin
                    found    = 1'b1;
                    best     = d2;
                    best_num = id_tab[i];
                end
            end
            if (found) begin
                // id number wraps at 9 bits before the split into letter and digit
                m        = best_num - 9'd1;
                r.matched = 1'b1;
                r.letter  = ASCII_A + CHAR_BITS'(m % NUM_LETTERS);
                r.digit   = ASCII_0 + CHAR_BITS'(m / NUM_LETTERS);
                r.number  = best_num;
            end else begin
                r.matched = 1'b0;
                r.letter  = UNMATCHED_CHAR;
                r.digit   = UNMATCHED_CHAR;
                r.number  = '0;
            end
            return r;
        endfunction

        // Accepted input item: loads update the table, queries queue an expected id
        function void note_item(t_storm_item it);
            if (it.op == OP_LOAD) begin
                if (it.idx < MAX_STORMS) begin
                    x_tab[it.idx]  = it.x;
                    y_tab[it.idx]  = it.y;
                    id_tab[it.idx] = it.num;
                end
            end else begin
                due_ids.push_back(nearest_id(it.x, it.y));
            end
        endfunction

        function void check_result(t_storm_id got);
            t_storm_id exp_id;
            if (due_ids.size() == 0) begin
                flag($sformatf("unexpected result: matched=%0d letter=%h digit=%h number=%0d",
                               got.matched, got.letter, got.digit, got.number));
                return;
            end
            exp_id = due_ids.pop_front();
            if (got.matched !== exp_id.matched || got.letter !== exp_id.letter ||
                got.digit !== exp_id.digit || got.number !== exp_id.number)
                flag($sformatf({"result mismatch: expected matched=%0d letter=%h digit=%h ",
                                "number=%0d, got matched=%0d letter=%h digit=%h number=%0d"},
                               exp_id.matched, exp_id.letter, exp_id.digit, exp_id.number,
                               got.matched, got.letter, got.digit, got.number));
        endfunction

        function int pending();
            return due_ids.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_ADDR-1:0] paddr;
    logic [APB_DATA-1:0] pwdata;
    logic [APB_DATA-1:0] prdata;
    logic                pready;

    nsim_in_if #(.COORD_BITS(COORD_BITS)) query_ch();
    nsim_out_if                           result_ch();

    storm_assoc_board board;
    int unsigned      cycles = 0;
    int               burst_left = 0;

    nearest_storm_id_match_core #(
        .MAX_STORMS (MAX_STORMS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            board.check_result({result_ch.matched, result_ch.id_letter,
                                result_ch.id_digit, result_ch.matched_number});
    end

    // Result stalls: a repeating 32-bit ready pattern that the loop redraws
    initial begin
        logic [31:0] ready_bits;
        int          k;
        result_ch.ready = 1'b0;
        ready_bits      = '1;
        k               = 0;
        forever begin
            @(negedge i_clk);
            if (k % 256 == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_bits = '1;
                    1: ready_bits = $urandom;
                    2: ready_bits = $urandom | $urandom;
                    default: ready_bits = $urandom & $urandom;
                endcase
                ready_bits[0] = 1'b1;
            end
            result_ch.ready <= ready_bits[k % 32];
            k++;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
        if (v > 8191)
            return 14'sd8191;
        if (v < -8192)
            return -14'sd8192;
        return v[COORD_BITS-1:0];
    endfunction

    // One item in bursts with random gaps; called and returns at a falling edge
    task automatic send_item(t_storm_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                query_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        query_ch.valid       <= 1'b1;
        query_ch.operation   <= it.op;
        query_ch.entry_index <= it.idx;
        query_ch.x_pos       <= it.x;
        query_ch.y_pos       <= it.y;
        query_ch.load_number <= it.num;
        do @(posedge i_clk); while (!query_ch.ready);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic load(int idx, int x, int y, int num);
        send_item('{OP_LOAD, IDX_BITS'(idx), to_coord(x), to_coord(y), ID_BITS'(num)});
    endtask

    task automatic query(int x, int y);
        send_item('{OP_QUERY, IDX_BITS'(0), to_coord(x), to_coord(y), ID_BITS'(0)});
    endtask

    // Stop items, wait for every result, then let a trailing load finish
    task automatic settle_block();
        query_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup then access, followed by idle with psel low
    task automatic reg_write(logic idx, logic [APB_DATA-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reg_check(logic idx, logic [APB_DATA-1:0] expected);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== expected)
            board.flag($sformatf("register %0d read: expected %0d, got %0d",
                                 idx, expected, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned count, int unsigned gate);
        reg_write(REG_STORM_COUNT, count);
        reg_write(REG_MAX_ASSOC_DIST, gate);
        reg_check(REG_STORM_COUNT, count);
        reg_check(REG_MAX_ASSOC_DIST, gate);
    endtask

    // Random item: storms mostly in a central cluster, queries mostly near a searched storm
    function automatic t_storm_item random_item();
        t_storm_item it;
        int          lim;
        int          s;
        int          reach;
        int          x;
        int          y;
        it.op  = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_QUERY;
        it.idx = IDX_BITS'($urandom_range(0, MAX_STORMS - 1));
        it.num = ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(1, 260));
        lim    = (board.storm_count > MAX_STORMS) ? MAX_STORMS : int'(board.storm_count);
        if (it.op == OP_QUERY && lim > 0 && $urandom_range(0, 3) != 0) begin
            s     = $urandom_range(0, lim - 1);
            reach = int'(board.gate) + 32;
            x     = int'(board.x_tab[s]) + int'($urandom_range(0, 2 * reach)) - reach;
            y     = int'(board.y_tab[s]) + int'($urandom_range(0, 2 * reach)) - reach;
            it.x  = to_coord(x);
            it.y  = to_coord(y);
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    it.x = COORD_BITS'($urandom);
                    it.y = COORD_BITS'($urandom);
                end
                1: begin
                    // same spot as another storm, for ties
                    s    = $urandom_range(0, MAX_STORMS - 1);
                    it.x = board.x_tab[s];
                    it.y = board.y_tab[s];
                end
                default: begin
                    it.x = to_coord(int'($urandom_range(0, 2048)) - 1024);
                    it.y = to_coord(int'($urandom_range(0, 2048)) - 1024);
                end
            endcase
        end
        return it;
    endfunction

    initial begin
        int unsigned phase_count[RANDOM_PHASES];
        int unsigned phase_gate[RANDOM_PHASES];
        t_storm_item it;
        int          p;
        int          i;

        phase_count = '{128, 255, 1, 0, 64, 0};
        phase_gate  = '{4095, 320, 2000, 320, 0, 0};
        phase_count[RANDOM_PHASES-1] = $urandom_range(0, MAX_STORMS);
        phase_gate[RANDOM_PHASES-1]  = $urandom_range(0, 1500);

        board                = new();
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        query_ch.valid       = 1'b0;
        query_ch.operation   = OP_LOAD;
        query_ch.entry_index = '0;
        query_ch.x_pos       = '0;
        query_ch.y_pos       = '0;
        query_ch.load_number = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values of the registers
        reg_check(REG_STORM_COUNT, APB_DATA'(STORM_COUNT_RST));
        reg_check(REG_MAX_ASSOC_DIST, APB_DATA'(GATE_RST));

        // Empty search: nothing matches
        query(0, 0);
        load(0, 100, 100, 1);
        load(1, 100, 100, 260);
        load(2, -8192, -8192, 0);
        load(3, 8191, 8191, 511);
        settle_block();
        set_config(4, 32'(GATE_RST));

        // Tie at distance zero goes to slot 0; gate edge is strict
        query(100, 100);
        query(419, 100);
        query(420, 100);
        // id numbers 0 and 511 give digit characters outside 0 to 9
        query(-8192, -8192);
        query(8191, 8191);
        load(0, -8192, 8191, 27);
        query(-8100, 8191);
        settle_block();
        set_config(4, 0);
        query(8191, 8191);
        query(-8192, 8191);
        settle_block();
        set_config(4, 4095);
        query(0, 0);
        query(-8192, -8100);
        settle_block();

        // Fill every slot so any count can be searched
        set_config(0, 32'(GATE_RST));
        for (i = 0; i < MAX_STORMS; i++) begin
            it     = random_item();
            it.op  = OP_LOAD;
            it.idx = IDX_BITS'(i);
            send_item(it);
        end
        settle_block();

        // Random phases over several register settings
        for (p = 0; p < RANDOM_PHASES; p++) begin
            set_config(phase_count[p], phase_gate[p]);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_item(random_item());
            settle_block();
        end

        board.mismatches += board.pending();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
